/* rtl/sitd_pkg.sv */
`default_nettype none
package sitd_pkg;

  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned CHAR_W      = 6;
  localparam int unsigned NUM_PLACES  = 5;
  localparam int unsigned PLACE_W     = 3;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned MAX_DIGIT   = 9;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

  localparam logic [PLACE_W-1:0] LAST_PLACE = PLACE_W'(NUM_PLACES - 1);

  // One classified number: sign flag and unsigned magnitude (up to 32768).
  typedef struct packed {
    logic                 neg;
    logic [VALUE_W-1:0]   mag;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t data;
  } queue_head_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIGIT
  } back_state_t;

  function automatic logic [VALUE_W-1:0] place_weight(input logic [PLACE_W-1:0] place);
    logic [VALUE_W-1:0] w;
    unique case (place)
      3'd0:    w = 16'd10000;
      3'd1:    w = 16'd1000;
      3'd2:    w = 16'd100;
      3'd3:    w = 16'd10;
      default: w = 16'd1;
    endcase
    return w;
  endfunction

  // k times the weight of a place; 9 * 10000 needs a seventeenth bit.
  function automatic logic [VALUE_W:0] place_multiple(input logic [PLACE_W-1:0] place,
                                                      input int unsigned k);
    return (VALUE_W + 1)'(k * int'(place_weight(place)));
  endfunction

endpackage
`default_nettype wire

/* rtl/signed_int_to_decimal_ascii.sv */
`default_nettype none
// Converts a signed 16-bit word into its decimal ASCII text, one character
// per output word, with out_last set on the final character. Negative
// numbers start with '-', zero prints as a single '0', and -32768 prints
// correctly as "-32768". A small queue decouples the input from the digit
// sequencer, so inputs are taken while earlier numbers are still printing.
// The sequencer handles one decimal place per cycle while the output is not
// stalled, plus a step for the minus sign when negative; an output stall
// pauses the sequencer. A number arriving at an idle block is first loaded
// from the queue into the sequencer.
module signed_int_to_decimal_ascii #(
  parameter int unsigned QUEUE_DEPTH = sitd_pkg::QUEUE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [sitd_pkg::VALUE_W-1:0] in_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [sitd_pkg::CHAR_W-1:0]              out_char_code,
  output logic                                     out_last
);

  logic                   push;
  sitd_pkg::item_t        push_item;
  logic                   queue_full;
  logic                   pop;
  sitd_pkg::queue_head_t  head;
  sitd_pkg::back_state_t  back_state;

  sitd_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  sitd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .head      (head)
  );

  sitd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .pop           (pop),
    .state         (back_state),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

  // A pending character that is not the last one means the sequencer is
  // still working on that number.
  a_busy_mid_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> back_state != sitd_pkg::ST_IDLE)
    else $error("sequencer idle in the middle of a number");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_code == sitd_pkg::CHAR_MINUS |-> !out_last)
    else $error("minus sign flagged as last character");

  // A minus sign is always followed by a digit of the same number.
  a_digit_after_minus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_char_code == sitd_pkg::CHAR_MINUS
    |=> back_state == sitd_pkg::ST_DIGIT || (out_valid && out_char_code != sitd_pkg::CHAR_MINUS))
    else $error("minus sign not followed by digits");

endmodule
`default_nettype wire

/* rtl/sitd_front.sv */
`default_nettype none
module sitd_front (
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [sitd_pkg::VALUE_W-1:0] in_value,
  input  wire logic                            queue_full,
  output logic                                 push,
  output sitd_pkg::item_t                      push_item
);

  logic [sitd_pkg::VALUE_W-1:0] raw;

  assign raw      = in_value;
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Two's complement negation in 16 unsigned bits; the most negative value
  // yields 32768, which still fits as an unsigned magnitude.
  always_comb begin
    push_item.neg = raw[sitd_pkg::VALUE_W-1];
    push_item.mag = raw[sitd_pkg::VALUE_W-1] ? (~raw + 16'd1) : raw;
  end

endmodule
`default_nettype wire

/* rtl/sitd_queue.sv */
`default_nettype none
module sitd_queue #(
  parameter int unsigned DEPTH = sitd_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire sitd_pkg::item_t push_item,
  output logic                 full,
  input  wire logic            pop,
  output sitd_pkg::queue_head_t head
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sitd_pkg::item_t  slot_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.data  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

/* rtl/sitd_back.sv */
`default_nettype none
module sitd_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire sitd_pkg::queue_head_t        head,
  output logic                              pop,
  output sitd_pkg::back_state_t             state,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [sitd_pkg::CHAR_W-1:0]       out_char_code,
  output logic                              out_last
);

  sitd_pkg::back_state_t              state_r, state_nxt;
  logic [sitd_pkg::PLACE_W-1:0]       place_r, place_nxt;
  logic [sitd_pkg::VALUE_W-1:0]       mag_r, mag_nxt;
  logic                               started_r, started_nxt;

  logic                               out_valid_r;
  logic [sitd_pkg::CHAR_W-1:0]        out_char_r;
  logic                               out_last_r;

  logic                               out_free;
  logic [sitd_pkg::DIGIT_W-1:0]       digit;
  logic [sitd_pkg::VALUE_W:0]         sub_amount;
  logic                               emit;
  logic [sitd_pkg::CHAR_W-1:0]        emit_char;
  logic                               emit_last;

  assign out_free      = !out_valid_r || !out_stall;
  assign state         = state_r;
  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

  // Digit of the current place: the multiples k*w that the magnitude reaches
  // are compared side by side, the highest one wins.
  always_comb begin
    digit      = '0;
    sub_amount = '0;
    for (int unsigned k = 1; k <= sitd_pkg::MAX_DIGIT; k++) begin
      if ({1'b0, mag_r} >= sitd_pkg::place_multiple(place_r, k)) begin
        digit      = sitd_pkg::DIGIT_W'(k);
        sub_amount = sitd_pkg::place_multiple(place_r, k);
      end
    end
  end

  // Output decode.
  always_comb begin
    emit      = 1'b0;
    emit_char = sitd_pkg::CHAR_ZERO;
    emit_last = 1'b0;
    pop       = 1'b0;
    unique case (state_r)
      sitd_pkg::ST_IDLE: begin
        pop = head.valid;
      end
      sitd_pkg::ST_SIGN: begin
        emit      = out_free;
        emit_char = sitd_pkg::CHAR_MINUS;
      end
      sitd_pkg::ST_DIGIT: begin
        // Leading zeros are dropped, but the units place always prints.
        emit      = out_free && (digit != '0 || started_r ||
                                 place_r == sitd_pkg::LAST_PLACE);
        emit_char = sitd_pkg::CHAR_ZERO + {2'b00, digit};
        emit_last = (place_r == sitd_pkg::LAST_PLACE);
        pop       = head.valid && out_free && (place_r == sitd_pkg::LAST_PLACE);
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt   = state_r;
    place_nxt   = place_r;
    mag_nxt     = mag_r;
    started_nxt = started_r;
    unique case (state_r)
      sitd_pkg::ST_IDLE: begin
        state_nxt = sitd_pkg::ST_IDLE;
      end
      sitd_pkg::ST_SIGN: begin
        if (out_free) begin
          state_nxt = sitd_pkg::ST_DIGIT;
        end
      end
      sitd_pkg::ST_DIGIT: begin
        if (out_free) begin
          if (place_r == sitd_pkg::LAST_PLACE) begin
            state_nxt = sitd_pkg::ST_IDLE;
          end else begin
            place_nxt   = place_r + 1'b1;
            mag_nxt     = mag_r - sub_amount[sitd_pkg::VALUE_W-1:0];
            started_nxt = started_r || (digit != '0);
          end
        end
      end
      default: begin
        state_nxt = sitd_pkg::ST_IDLE;
      end
    endcase
    if (pop) begin
      state_nxt   = head.data.neg ? sitd_pkg::ST_SIGN : sitd_pkg::ST_DIGIT;
      place_nxt   = '0;
      mag_nxt     = head.data.mag;
      started_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sitd_pkg::ST_IDLE;
      place_r     <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      place_r   <= place_nxt;
      started_r <= started_nxt;
      if (out_free) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    if (emit) begin
      out_char_r <= emit_char;
      out_last_r <= emit_last;
    end
  end

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_WORDS   = 400;
  localparam int unsigned CALM_WORDS     = 60;
  localparam int unsigned WATCHDOG_LIMIT = 500;
  localparam int unsigned TAIL_CYCLES    = 20;

  typedef struct {
    logic [sitd_pkg::VALUE_W-1:0] value;
    int unsigned                  gap;
    bit                           drain;
    bit                           calm;
  } word_plan_t;

  typedef struct packed {
    logic [sitd_pkg::CHAR_W-1:0] code;
    logic                        last;
  } text_char_t;

  logic                                clk       = 1'b0;
  logic                                rst_n     = 1'b0;
  logic                                in_valid  = 1'b0;
  logic signed [sitd_pkg::VALUE_W-1:0] in_value  = '0;
  logic                                out_stall = 1'b0;
  logic                                in_stall;
  logic                                out_valid;
  logic [sitd_pkg::CHAR_W-1:0]         out_char_code;
  logic                                out_last;

  word_plan_t  pending_words[$];
  text_char_t  expected_chars[$];
  int unsigned mismatches  = 0;
  int unsigned gap_left    = 0;
  bit          gap_loaded  = 1'b0;
  bit          calm_phase  = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned stall_pct   = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_cycles = 0;

  signed_int_to_decimal_ascii uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_code(out_char_code),
    .out_last     (out_last)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Expected text of one word: optional minus sign, then digits with leading
  // zeros dropped. The magnitude has a seventeenth bit so -32768 is exact.
  task automatic push_decimal_text(input logic [sitd_pkg::VALUE_W-1:0] raw);
    int unsigned                 weight [5] = '{10000, 1000, 100, 10, 1};
    logic [sitd_pkg::CHAR_W-1:0] text [6];
    logic [sitd_pkg::VALUE_W:0]  mag;
    int unsigned                 rest;
    int unsigned                 digit;
    int unsigned                 n;
    bit                          leading;
    text_char_t                  ch;
    n = 0;
    leading = 1'b0;
    if (raw[sitd_pkg::VALUE_W-1]) begin
      text[n] = sitd_pkg::CHAR_MINUS;
      n++;
      mag = 17'h10000 - {1'b0, raw};
    end else begin
      mag = {1'b0, raw};
    end
    rest = 32'(mag);
    if (rest == 0) begin
      text[n] = sitd_pkg::CHAR_ZERO;
      n++;
    end else begin
      for (int p = 0; p < 5; p++) begin
        digit = rest / weight[p];
        rest  = rest % weight[p];
        if (digit != 0 || leading) begin
          text[n] = sitd_pkg::CHAR_ZERO + sitd_pkg::CHAR_W'(digit);
          n++;
          leading = 1'b1;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      ch.code = text[i];
      ch.last = (i == n - 1);
      expected_chars.push_back(ch);
    end
  endtask

  function automatic logic [sitd_pkg::VALUE_W-1:0] random_value();
    int unsigned       pick;
    int                v;
    int unsigned       powers [5] = '{1, 10, 100, 1000, 10000};
    pick = $urandom_range(99);
    if (pick < 40) begin
      v = $urandom_range(16'hFFFF);
    end else if (pick < 60) begin
      v = int'($urandom_range(198)) - 99;
    end else if (pick < 80) begin
      v = int'(powers[$urandom_range(4)]) + int'($urandom_range(4)) - 2;
      if ($urandom_range(1)) v = -v;
    end else if (pick < 90) begin
      v = $urandom_range(1) ? 32767 - int'($urandom_range(7)) : -32768 + int'($urandom_range(7));
    end else begin
      v = int'($urandom_range(18)) - 9;
    end
    return sitd_pkg::VALUE_W'(v);
  endfunction

  task automatic plan_word(input logic [sitd_pkg::VALUE_W-1:0] value, input int unsigned gap,
                           input bit drain, input bit calm);
    word_plan_t w;
    w.value = value;
    w.gap   = gap;
    w.drain = drain;
    w.calm  = calm;
    pending_words.push_back(w);
  endtask

  // Driver: a presented word is held until taken, then the next one follows
  // at once or after its planned gap; a word marked drain also waits for the output to empty.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        push_decimal_text(in_value);
      end
      if (!(in_valid && in_stall)) begin
        if (pending_words.size() != 0 && !gap_loaded) begin
          gap_left   = pending_words[0].gap;
          gap_loaded = 1'b1;
        end
        if (pending_words.size() != 0 && gap_left == 0 &&
            (!pending_words[0].drain || (expected_chars.size() == 0 && !out_valid))) begin
          in_value   <= pending_words[0].value;
          in_valid   <= 1'b1;
          calm_phase = pending_words[0].calm;
          pending_words.pop_front();
          gap_loaded = 1'b0;
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // Monitor: checks each taken character and drives output back-pressure.
  always @(posedge clk) begin
    text_char_t want;
    cycle_count++;
    if (cycle_count % 100 == 0) begin
      case ($urandom_range(3))
        0:       stall_pct = 0;
        1:       stall_pct = 15;
        2:       stall_pct = 40;
        default: stall_pct = 70;
      endcase
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("character with no word pending", int'(out_char_code), 0);
        end else begin
          want = expected_chars.pop_front();
          if (out_char_code !== want.code) begin
            report_mismatch("char_code", int'(out_char_code), int'(want.code));
          end
          if (out_last !== want.last) begin
            report_mismatch("last", int'(out_last), int'(want.last));
          end
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (out_stall) begin
        out_stall <= 1'b0;
      end else if (!calm_phase && $urandom_range(99) < stall_pct) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(3);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [sitd_pkg::VALUE_W-1:0] directed [$];
    int unsigned                  gap_mode;
    int unsigned                  gap;
    bit                           calm;
    directed = '{16'd0, 16'd1, 16'hFFFF, 16'd32767, 16'h8000, 16'd9, 16'd10,
                 -16'sd10, 16'd99, 16'd100, 16'd999, 16'd1000, 16'd9999,
                 16'd10000, -16'sd10000, 16'd10001, 16'd12345, -16'sd12345,
                 16'h5555, 16'hAAAA, 16'd20000, -16'sd9, 16'h8001};
    foreach (directed[i]) begin
      plan_word(directed[i], (i % 3 == 0) ? $urandom_range(1, 4) : 0, i == 5, 1'b0);
    end
    gap_mode = 0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      calm = (i >= RANDOM_WORDS - CALM_WORDS);
      if (i % 40 == 0) gap_mode = $urandom_range(2);
      gap = 0;
      if (!calm) begin
        if (gap_mode == 1 && $urandom_range(99) < 20) gap = $urandom_range(1, 4);
        if (gap_mode == 2 && $urandom_range(99) < 60) gap = $urandom_range(1, 4);
      end
      // Now and then the sender holds off until every character has drained.
      plan_word(random_value(), gap, !calm && (i % 97 == 50), calm);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_words.size() != 0 || in_valid || expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
